### hdl/fkie_pkg.sv
package fkie_pkg;

  localparam int unsigned NUM_SLOTS_DEF = 1024;
  localparam int unsigned KEY_BYTES_DEF = 4;
  localparam int unsigned ADDR_BITS     = 32;

  localparam int unsigned KEY_IN_W   = 32;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned SLOT_W     = 10;
  localparam int unsigned CFG_W      = 25;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned DIVR_W     = 17;
  localparam int unsigned MUL_B_W    = 25;
  localparam int unsigned OUT_PAD_W  = 3;
  localparam int unsigned OUT_DATA_W = 2 * SLOT_W + 2 * ADDR_W + 1 + OUT_PAD_W;

  localparam logic [ADDR_W-1:0] ADDR_MASK =
      (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} : ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

  localparam logic [12:0] RST_INDEX_SECTORS    = 13'd0;
  localparam logic [12:0] RST_PAGES_PER_SECTOR = 13'd16;
  localparam logic [16:0] RST_PAGE_BYTES       = 17'd256;
  localparam logic [24:0] RST_SECTOR_BYTES     = 25'd4096;
  localparam logic [16:0] RST_SLOTS_PER_PAGE   = 17'd64;
  localparam logic [16:0] RST_RECORDS_PER_PAGE = 17'd6;
  localparam logic [16:0] RST_RECORD_STRIDE    = 17'd40;

  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_STORE  = 2'd1,
    ACT_ERASE  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INDEX_SECTORS    = 3'd0,
    CFG_PAGES_PER_SECTOR = 3'd1,
    CFG_PAGE_BYTES       = 3'd2,
    CFG_SECTOR_BYTES     = 3'd3,
    CFG_SLOTS_PER_PAGE   = 3'd4,
    CFG_RECORDS_PER_PAGE = 3'd5,
    CFG_RECORD_STRIDE    = 3'd6
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CNT_A,
    ST_CNT_B,
    ST_CNT_C,
    ST_SCAN,
    ST_WR_DEL,
    ST_WR_KEY,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_MUL,
    ST_ACC,
    ST_DONE
  } state_e;

endpackage

### hdl/flash_key_index_engine_core.sv
// Channel   Direction  Handshake              Payload
// s         in         s_tvalid_i/s_tready_o  tdata: key; tuser: action
// m         out        m_tvalid_o/m_tready_i  tdata: slot, addresses, replaced; tuser: status
// cfg       in         cfg_we_i               cfg_idx_i, cfg_data_i
//
// A lookup that finds its key first works out the scan count, then reads S slots, one a cycle,
// where S is at most the scan count plus one, then makes four divider passes and six multiply
// and add steps. A store does the same and also writes its key, after zeroing an earlier copy
// when it found one. A miss or a full index ends after the scan; an erase or an unused action
// goes straight to the result. Input is taken only in the idle state; a stalled result
// waits in the output register. After reset every slot reads as erased through the fill count.
module flash_key_index_engine_core #(
  parameter int unsigned NUM_SLOTS = fkie_pkg::NUM_SLOTS_DEF,
  parameter int unsigned KEY_BYTES = fkie_pkg::KEY_BYTES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fkie_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fkie_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                            s_tvalid_i,
  output logic                            s_tready_o,
  input  logic [fkie_pkg::KEY_IN_W-1:0]   s_tdata_i,   // key
  input  logic [1:0]                      s_tuser_i,   // action
  output logic                            m_tvalid_o,
  input  logic                            m_tready_i,
  // slot_index, key_addr, record_addr, replaced, replaced_slot, zero fill
  output logic [fkie_pkg::OUT_DATA_W-1:0] m_tdata_o,
  output logic [1:0]                      m_tuser_o    // status
);
  import fkie_pkg::*;

  localparam int unsigned IDX_W   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CNT_W   = $clog2(NUM_SLOTS + 1);
  localparam int unsigned KEY_W   = 8 * ((KEY_BYTES >= 4) ? 4 : KEY_BYTES);
  localparam int unsigned MA_T    = (CNT_W > IDX_W + 1) ? CNT_W : IDX_W + 1;
  localparam int unsigned MA_W    = (MA_T > 14) ? MA_T : 14;
  localparam int unsigned PROD_W  = MA_W + MUL_B_W;
  localparam int unsigned STEP_W  = 3;
  localparam logic [STEP_W-1:0] DIV_LAST     = 3'd3;
  localparam logic [STEP_W-1:0] MAC_KEY_LAST = 3'd2;
  localparam logic [STEP_W-1:0] MAC_LAST     = 3'd5;

  state_e state_q, state_d;

  logic [12:0] idx_sec_q, pps_q;
  logic [16:0] page_b_q, spp_q, rpp_q, stride_q;
  logic [24:0] sec_b_q;

  action_e           action_q, action_d;
  status_e           status_q, status_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [CNT_W-1:0]  n_q, n_d;
  logic [CNT_W-1:0]  s_q, s_d;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic              hit_q, hit_d;
  logic [IDX_W-1:0]  match_q, match_d;
  logic [IDX_W-1:0]  tgt_q, tgt_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [IDX_W-1:0]  quo_q, quo_d;
  logic [IDX_W-1:0]  pos_q, pos_d, pg_q, pg_d, sec_q, sec_d;
  logic [IDX_W-1:0]  rnum_q, rnum_d, rpage_q, rpage_d, rsec_q, rsec_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [ADDR_W-1:0] acc_q, acc_d, kaddr_q, kaddr_d, raddr_q, raddr_d;
  logic              m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0] m_data_q, m_data_d;
  logic [1:0]        m_user_q, m_user_d;

  logic [KEY_W-1:0]  mem_q [NUM_SLOTS];
  logic [KEY_W-1:0]  rd_q;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [KEY_W-1:0]  mem_wdata;

  logic [MA_W-1:0]    mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [CNT_W-1:0]   cnt_sat;

  logic              div_start, div_done;
  logic [IDX_W-1:0]  div_dvd, div_q, div_r;
  logic [DIVR_W-1:0] div_raw, div_dvs;

  logic              in_accept, out_free;
  logic              in_rng, erased, hit_now, free_now, scan_stop;
  logic              addr_en, rep_en;
  logic [ADDR_W-1:0] acc_sum;

  assign in_accept = s_tvalid_i && s_tready_o;
  assign out_free  = !m_valid_q || m_tready_i;
  assign s_tready_o = (state_q == ST_IDLE);

  assign cnt_sat = (prod_q > PROD_W'(NUM_SLOTS)) ? CNT_W'(NUM_SLOTS) : prod_q[CNT_W-1:0];
  assign prod_d  = mul_a * mul_b;
  assign acc_sum = acc_q + prod_q[ADDR_W-1:0];

  // Slots at or beyond the fill count are erased; below it they are live or deleted.
  assign in_rng   = (s_q < n_q);
  assign erased   = (s_q >= fill_q);
  assign hit_now  = in_rng && !erased && (rd_q != '0) && (rd_q == key_q);
  assign free_now = in_rng && erased;
  assign scan_stop = (action_q == ACT_LOOKUP) ? (!in_rng || erased || hit_now)
                                               : (!in_rng || erased);

  assign addr_en = (status_q == STAT_OK) &&
                   ((action_q == ACT_LOOKUP) || (action_q == ACT_STORE));
  assign rep_en  = addr_en && (action_q == ACT_STORE) && hit_q;

  fkie_div #(
    .DVD_W (IDX_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_q),
    .rem_o      (div_r)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if ((s_tuser_i == ACT_LOOKUP) || (s_tuser_i == ACT_STORE)) begin
            state_d = ST_CNT_A;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_CNT_A: state_d = ST_CNT_B;
      ST_CNT_B: state_d = ST_CNT_C;
      ST_CNT_C: state_d = ST_SCAN;
      ST_SCAN: begin
        if (scan_stop) begin
          if (action_q == ACT_LOOKUP) begin
            state_d = hit_now ? ST_DIV_GO : ST_DONE;
          end else if (free_now) begin
            state_d = hit_q ? ST_WR_DEL : ST_WR_KEY;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_WR_DEL: state_d = ST_WR_KEY;
      ST_WR_KEY: state_d = ST_DIV_GO;
      ST_DIV_GO: state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_d = (step_q == DIV_LAST) ? ST_MUL : ST_DIV_GO;
        end
      end
      ST_MUL: state_d = ST_ACC;
      ST_ACC: state_d = (step_q == MAC_LAST) ? ST_DONE : ST_MUL;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    action_d  = action_q;
    status_d  = status_q;
    key_d     = key_q;
    n_d       = n_q;
    s_d       = s_q;
    fill_d    = fill_q;
    hit_d     = hit_q;
    match_d   = match_q;
    tgt_d     = tgt_q;
    step_d    = step_q;
    quo_d     = quo_q;
    pos_d     = pos_q;
    pg_d      = pg_q;
    sec_d     = sec_q;
    rnum_d    = rnum_q;
    rpage_d   = rpage_q;
    rsec_d    = rsec_q;
    acc_d     = acc_q;
    kaddr_d   = kaddr_q;
    raddr_d   = raddr_q;
    m_valid_d = m_valid_q && !m_tready_i;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    mem_we    = 1'b0;
    mem_waddr = tgt_q;
    mem_wdata = key_q;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_dvd   = tgt_q;
    div_raw   = spp_q;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          action_d = action_e'(s_tuser_i);
          key_d    = s_tdata_i[KEY_W-1:0];
          hit_d    = 1'b0;
          status_d = STAT_OK;
          if (s_tuser_i == ACT_ERASE) begin
            fill_d = '0;
          end else if (s_tuser_i != ACT_LOOKUP && s_tuser_i != ACT_STORE) begin
            status_d = STAT_MISS;
          end
        end
      end
      ST_CNT_A: begin
        mul_a = MA_W'(idx_sec_q);
        mul_b = MUL_B_W'(pps_q);
      end
      ST_CNT_B: begin
        mul_a = MA_W'(cnt_sat);
        mul_b = MUL_B_W'(spp_q);
      end
      ST_CNT_C: begin
        n_d     = cnt_sat;
        s_d     = '0;
        hit_d   = 1'b0;
        match_d = '0;
      end
      ST_SCAN: begin
        s_d = s_q + CNT_W'(1);
        if (hit_now) begin
          hit_d   = 1'b1;
          match_d = s_q[IDX_W-1:0];
        end
        if (scan_stop) begin
          tgt_d  = s_q[IDX_W-1:0];
          step_d = '0;
          if (action_q == ACT_LOOKUP) begin
            status_d = hit_now ? STAT_OK : STAT_MISS;
          end else begin
            status_d = free_now ? STAT_OK : STAT_FULL;
          end
        end
      end
      ST_WR_DEL: begin
        mem_we    = 1'b1;
        mem_waddr = match_q;
        mem_wdata = '0;
      end
      ST_WR_KEY: begin
        mem_we = 1'b1;
        if (key_q != '1) begin
          fill_d = fill_q + CNT_W'(1);
        end
      end
      ST_DIV_GO: begin
        div_start = 1'b1;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          case (step_q)
            3'd0: begin
              quo_d = div_q;
              pos_d = div_r;
            end
            3'd1: begin
              sec_d = div_q;
              pg_d  = div_r;
            end
            3'd2: begin
              quo_d  = div_q;
              rnum_d = div_r;
            end
            default: begin
              rsec_d  = div_q;
              rpage_d = div_r;
            end
          endcase
          step_d = (step_q == DIV_LAST) ? '0 : step_q + STEP_W'(1);
          acc_d  = '0;
        end
      end
      ST_MUL: begin
        case (step_q)
          3'd0: begin
            mul_a = MA_W'(sec_q);
            mul_b = sec_b_q;
          end
          3'd1: begin
            mul_a = MA_W'(pg_q);
            mul_b = MUL_B_W'(page_b_q);
          end
          3'd2: begin
            mul_a = MA_W'(pos_q);
            mul_b = MUL_B_W'(KEY_BYTES);
          end
          3'd3: begin
            mul_a = MA_W'(idx_sec_q) + MA_W'(rsec_q);
            mul_b = sec_b_q;
          end
          3'd4: begin
            mul_a = MA_W'(rpage_q);
            mul_b = MUL_B_W'(page_b_q);
          end
          default: begin
            mul_a = MA_W'(rnum_q);
            mul_b = MUL_B_W'(stride_q);
          end
        endcase
      end
      ST_ACC: begin
        step_d = step_q + STEP_W'(1);
        if (step_q == MAC_KEY_LAST) begin
          kaddr_d = acc_sum;
          acc_d   = '0;
        end else if (step_q == MAC_LAST) begin
          raddr_d = acc_sum;
        end else begin
          acc_d = acc_sum;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_user_d  = status_q;
          m_data_d  = {{OUT_PAD_W{1'b0}},
                       rep_en ? SLOT_W'(match_q) : {SLOT_W{1'b0}},
                       rep_en,
                       addr_en ? (raddr_q & ADDR_MASK) : {ADDR_W{1'b0}},
                       addr_en ? (kaddr_q & ADDR_MASK) : {ADDR_W{1'b0}},
                       addr_en ? SLOT_W'(tgt_q) : {SLOT_W{1'b0}}};
        end
      end
      default: ;
    endcase

    // The first key step divides by slots per page, the first record step by records per page, the others by pages.
    if ((step_q == 3'd1) || (step_q == 3'd3)) begin
      div_dvd = quo_q;
      div_raw = DIVR_W'(pps_q);
    end else if (step_q == 3'd2) begin
      div_raw = rpp_q;
    end
  end

  assign div_dvs = (div_raw == '0) ? DIVR_W'(1) : div_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fill_q    <= '0;
      m_valid_q <= 1'b0;
      idx_sec_q <= RST_INDEX_SECTORS;
      pps_q     <= RST_PAGES_PER_SECTOR;
      page_b_q  <= RST_PAGE_BYTES;
      sec_b_q   <= RST_SECTOR_BYTES;
      spp_q     <= RST_SLOTS_PER_PAGE;
      rpp_q     <= RST_RECORDS_PER_PAGE;
      stride_q  <= RST_RECORD_STRIDE;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_INDEX_SECTORS:    idx_sec_q <= cfg_data_i[12:0];
          CFG_PAGES_PER_SECTOR: pps_q     <= cfg_data_i[12:0];
          CFG_PAGE_BYTES:       page_b_q  <= cfg_data_i[16:0];
          CFG_SECTOR_BYTES:     sec_b_q   <= cfg_data_i[24:0];
          CFG_SLOTS_PER_PAGE:   spp_q     <= cfg_data_i[16:0];
          CFG_RECORDS_PER_PAGE: rpp_q     <= cfg_data_i[16:0];
          CFG_RECORD_STRIDE:    stride_q  <= cfg_data_i[16:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    action_q <= action_d;
    status_q <= status_d;
    key_q    <= key_d;
    n_q      <= n_d;
    s_q      <= s_d;
    hit_q    <= hit_d;
    match_q  <= match_d;
    tgt_q    <= tgt_d;
    step_q   <= step_d;
    quo_q    <= quo_d;
    pos_q    <= pos_d;
    pg_q     <= pg_d;
    sec_q    <= sec_d;
    rnum_q   <= rnum_d;
    rpage_q  <= rpage_d;
    rsec_q   <= rsec_d;
    prod_q   <= prod_d;
    acc_q    <= acc_d;
    kaddr_q  <= kaddr_d;
    raddr_q  <= raddr_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem_q[s_d[IDX_W-1:0]];
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;
  assign m_tuser_o  = m_user_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(NUM_SLOTS))
    else $error("fill count beyond slot count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WR_KEY) |-> (CNT_W'(tgt_q) == fill_q))
    else $error("key written away from the first erased slot");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WR_DEL) |-> (match_q < tgt_q))
    else $error("deleted slot not below the written slot");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV_WAIT))
    else $error("divider finished outside its wait state");

endmodule

### hdl/fkie_div.sv
module fkie_div #(
  parameter int unsigned DVD_W = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [DVD_W-1:0]            dividend_i,
  input  logic [fkie_pkg::DIVR_W-1:0] divisor_i,
  output logic                        done_o,
  output logic [DVD_W-1:0]            quot_o,
  output logic [DVD_W-1:0]            rem_o
);
  import fkie_pkg::*;

  localparam int unsigned CW = $clog2(DVD_W + 1);
  localparam int unsigned RW = (DVD_W + 1 > DIVR_W) ? DVD_W + 1 : DIVR_W;

  logic              busy_q;
  logic              done_q;
  logic [CW-1:0]     cnt_q;
  logic [DVD_W-1:0]  q_q;
  logic [DVD_W-1:0]  r_q;
  logic [DIVR_W-1:0] d_q;

  logic [RW-1:0]    trial;
  logic [RW-1:0]    diff;
  logic             ge;
  logic [DVD_W-1:0] r_step;
  logic [DVD_W:0]   q_shift;

  // One quotient bit per cycle, restoring shift and subtract.
  always_comb begin
    trial   = RW'({r_q, q_q[DVD_W-1]});
    diff    = trial - RW'(d_q);
    ge      = (trial >= RW'(d_q));
    r_step  = ge ? diff[DVD_W-1:0] : trial[DVD_W-1:0];
    q_shift = {q_q, ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CW'(1);
      if (cnt_q == CW'(DVD_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= dividend_i;
      r_q <= '0;
      d_q <= divisor_i;
    end else if (busy_q) begin
      q_q <= q_shift[DVD_W-1:0];
      r_q <= r_step;
    end
  end

  assign done_o = done_q;
  assign quot_o = q_q;
  assign rem_o  = r_q;

endmodule

### verif/flash_key_index_engine_core_tb.sv
`timescale 1ns / 100ps

module flash_key_index_engine_core_tb;
  import fkie_pkg::*;

  localparam int unsigned NUM_SLOTS   = NUM_SLOTS_DEF;
  localparam int unsigned KEY_BYTES   = KEY_BYTES_DEF;
  localparam logic [1:0]  ACT_UNUSED  = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned IDLE_GAP    = 8;
  localparam int unsigned TAIL_CYCLES = 64;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned HOLD_AT     = 220;
  localparam int unsigned SWAP_AT     = 190;
  localparam int unsigned QUIET_AT    = 380;
  localparam int unsigned DIR_ROWS    = 22;
  localparam int unsigned DIR_SPLIT   = 4;

  typedef struct packed {
    status_e     status;
    logic [9:0]  slot;
    logic [31:0] key_addr;
    logic [31:0] rec_addr;
    logic        replaced;
    logic [9:0]  repl_slot;
  } index_answer_t;

  typedef struct packed {
    logic [1:0]    act;
    logic [31:0]   key;
    logic          typed;
    index_answer_t want;
  } directed_row_t;

  localparam index_answer_t ANS_CLEAR = '{STAT_OK, 10'd0, 32'd0, 32'd0, 1'b0, 10'd0};
  localparam index_answer_t ANS_MISS  = '{STAT_MISS, 10'd0, 32'd0, 32'd0, 1'b0, 10'd0};
  localparam index_answer_t ANS_FULL  = '{STAT_FULL, 10'd0, 32'd0, 32'd0, 1'b0, 10'd0};
  localparam index_answer_t ANS_FIRST = '{STAT_OK, 10'd0, 32'd0, 32'd4096, 1'b0, 10'd0};

  localparam directed_row_t DIRECTED [DIR_ROWS] = '{
    '{ACT_LOOKUP, 32'h1234_5678, 1'b1, ANS_MISS},
    '{ACT_STORE,  32'h1234_5678, 1'b1, ANS_FULL},
    '{ACT_ERASE,  32'h0000_0000, 1'b1, ANS_CLEAR},
    '{ACT_UNUSED, 32'hFFFF_FFFF, 1'b1, ANS_MISS},
    '{ACT_STORE,  32'h0000_0001, 1'b1, ANS_FIRST},
    '{ACT_STORE,  32'hFFFF_FFFE, 1'b0, ANS_CLEAR},
    '{ACT_STORE,  32'h0000_0001, 1'b0, ANS_CLEAR},
    '{ACT_LOOKUP, 32'h0000_0001, 1'b0, ANS_CLEAR},
    '{ACT_STORE,  32'hFFFF_FFFF, 1'b0, ANS_CLEAR},
    '{ACT_LOOKUP, 32'hFFFF_FFFF, 1'b1, ANS_MISS},
    '{ACT_STORE,  32'h0000_0000, 1'b0, ANS_CLEAR},
    '{ACT_LOOKUP, 32'h0000_0000, 1'b1, ANS_MISS},
    '{ACT_STORE,  32'h8000_0000, 1'b0, ANS_CLEAR},
    '{ACT_STORE,  32'h7FFF_FFFF, 1'b0, ANS_CLEAR},
    '{ACT_STORE,  32'hA5A5_A5A5, 1'b0, ANS_CLEAR},
    '{ACT_STORE,  32'h5A5A_5A5A, 1'b0, ANS_CLEAR},
    '{ACT_STORE,  32'hDEAD_BEEF, 1'b1, ANS_FULL},
    '{ACT_LOOKUP, 32'hFFFF_FFFE, 1'b0, ANS_CLEAR},
    '{ACT_LOOKUP, 32'hCAFE_F00D, 1'b1, ANS_MISS},
    '{ACT_UNUSED, 32'h0000_0001, 1'b1, ANS_MISS},
    '{ACT_ERASE,  32'hFFFF_FFFF, 1'b1, ANS_CLEAR},
    '{ACT_LOOKUP, 32'h0000_0001, 1'b1, ANS_MISS}
  };

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [CFG_W-1:0]      cfg_data_i = '0;
  logic                  s_tvalid_i = 1'b0;
  logic                  s_tready_o;
  logic [KEY_IN_W-1:0]   s_tdata_i  = '0;
  logic [1:0]            s_tuser_i  = '0;
  logic                  m_tvalid_o;
  logic                  m_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata_o;
  logic [1:0]            m_tuser_o;

  logic [31:0] slot_mem [NUM_SLOTS];
  logic [12:0] reg_isec;
  logic [12:0] reg_pps;
  logic [16:0] reg_pb;
  logic [24:0] reg_sb;
  logic [16:0] reg_spp;
  logic [16:0] reg_rpp;
  logic [16:0] reg_stride;

  index_answer_t pending_answers [$];
  int unsigned   send_idle_pct = 31;
  int unsigned   recv_idle_pct = 49;
  int unsigned   items_sent    = 0;
  int unsigned   answers_seen  = 0;
  int unsigned   settings_used = 0;
  int unsigned   hits_seen     = 0;
  int unsigned   replaced_seen = 0;
  int unsigned   full_seen     = 0;
  int unsigned   mismatches    = 0;
  int unsigned   cycle_count   = 0;
  int unsigned   hold_left     = 0;
  bit            hold_done     = 1'b0;

  flash_key_index_engine_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic longint unsigned at_least_one(input longint unsigned v);
    return (v == 0) ? 64'd1 : v;
  endfunction

  function automatic logic [31:0] slot_key_address(input longint unsigned idx);
    longint unsigned spp;
    longint unsigned pps;
    longint unsigned a;
    spp = at_least_one(64'(reg_spp));
    pps = at_least_one(64'(reg_pps));
    a = (idx / spp / pps) * reg_sb + ((idx / spp) % pps) * reg_pb
        + (idx % spp) * KEY_BYTES;
    return 32'(a) & ADDR_MASK;
  endfunction

  function automatic logic [31:0] slot_record_address(input longint unsigned idx);
    longint unsigned rpp;
    longint unsigned pps;
    longint unsigned q;
    longint unsigned a;
    rpp = at_least_one(64'(reg_rpp));
    pps = at_least_one(64'(reg_pps));
    q = idx / rpp;
    a = (64'(reg_isec) + q / pps) * reg_sb + (q % pps) * reg_pb
        + (idx % rpp) * reg_stride;
    return 32'(a) & ADDR_MASK;
  endfunction

  // Updates the slot copy as the block would and returns the answer it should give.
  function automatic index_answer_t index_answer(input logic [1:0] act,
                                                 input logic [31:0] key);
    index_answer_t   ans;
    longint unsigned span;
    longint unsigned i;
    longint unsigned hit_at;
    longint unsigned free_at;
    bit              hit;
    bit              free_found;
    ans        = ANS_CLEAR;
    hit        = 1'b0;
    free_found = 1'b0;
    hit_at     = 0;
    free_at    = 0;
    span = 64'(reg_isec) * 64'(reg_pps) * 64'(reg_spp);
    if (span > NUM_SLOTS) span = NUM_SLOTS;
    if (act == ACT_ERASE) begin
      foreach (slot_mem[j]) slot_mem[j] = '1;
      return ans;
    end
    if (act == ACT_UNUSED) begin
      ans.status = STAT_MISS;
      return ans;
    end
    for (i = 0; i < span; i++) begin
      if (slot_mem[i] == '1) begin
        free_found = 1'b1;
        free_at    = i;
        break;
      end
      if (slot_mem[i] != '0 && slot_mem[i] == key) begin
        hit    = 1'b1;
        hit_at = i;
        if (act == ACT_LOOKUP) break;
      end
    end
    if (act == ACT_LOOKUP) begin
      if (!hit) begin
        ans.status = STAT_MISS;
      end else begin
        ans.slot     = 10'(hit_at);
        ans.key_addr = slot_key_address(hit_at);
        ans.rec_addr = slot_record_address(hit_at);
      end
      return ans;
    end
    if (!free_found) begin
      ans.status = STAT_FULL;
      return ans;
    end
    if (hit) begin
      slot_mem[hit_at] = '0;
      ans.replaced     = 1'b1;
      ans.repl_slot    = 10'(hit_at);
    end
    slot_mem[free_at] = key;
    ans.slot     = 10'(free_at);
    ans.key_addr = slot_key_address(free_at);
    ans.rec_addr = slot_record_address(free_at);
    return ans;
  endfunction

  task automatic offer_item(input logic [1:0] act, input logic [31:0] key,
                            input logic typed, input index_answer_t want);
    index_answer_t predicted;
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= key;
    s_tuser_i  <= act;
    do @(posedge clk_i); while (!s_tready_o);
    predicted = index_answer(act, key);
    pending_answers.push_back(typed ? want : predicted);
    items_sent++;
    if (items_sent == SWAP_AT) begin
      send_idle_pct = 49;
      recv_idle_pct = 31;
    end else if (items_sent == QUIET_AT) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  task automatic wait_idle();
    s_tvalid_i <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (IDLE_GAP) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int unsigned value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_W'(value);
    @(posedge clk_i);
    case (idx)
      CFG_INDEX_SECTORS:    reg_isec   = 13'(value);
      CFG_PAGES_PER_SECTOR: reg_pps    = 13'(value);
      CFG_PAGE_BYTES:       reg_pb     = 17'(value);
      CFG_SECTOR_BYTES:     reg_sb     = 25'(value);
      CFG_SLOTS_PER_PAGE:   reg_spp    = 17'(value);
      CFG_RECORDS_PER_PAGE: reg_rpp    = 17'(value);
      CFG_RECORD_STRIDE:    reg_stride = 17'(value);
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_setting(input int unsigned isec, input int unsigned pps,
                               input int unsigned pb, input int unsigned sb,
                               input int unsigned spp, input int unsigned rpp,
                               input int unsigned stride);
    wait_idle();
    write_reg(CFG_INDEX_SECTORS, isec);
    write_reg(CFG_PAGES_PER_SECTOR, pps);
    write_reg(CFG_PAGE_BYTES, pb);
    write_reg(CFG_SECTOR_BYTES, sb);
    write_reg(CFG_SLOTS_PER_PAGE, spp);
    write_reg(CFG_RECORDS_PER_PAGE, rpp);
    write_reg(CFG_RECORD_STRIDE, stride);
    settings_used++;
  endtask

  // Mostly stores and lookups over a small pool of keys, so that copies get replaced and
  // the index fills up, with some stray keys, erases and unused actions mixed in.
  task automatic run_phase(input int unsigned count);
    logic [31:0] key_pool [8];
    int unsigned pick;
    foreach (key_pool[p]) key_pool[p] = $urandom;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        offer_item(ACT_STORE, key_pool[$urandom_range(7)], 1'b0, ANS_CLEAR);
      end else if (pick < 75) begin
        offer_item(ACT_LOOKUP, key_pool[$urandom_range(7)], 1'b0, ANS_CLEAR);
      end else if (pick < 85) begin
        offer_item(ACT_LOOKUP, $urandom, 1'b0, ANS_CLEAR);
      end else if (pick < 90) begin
        offer_item(ACT_STORE, $urandom, 1'b0, ANS_CLEAR);
      end else if (pick < 93) begin
        offer_item(ACT_STORE, $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0, 1'b0, ANS_CLEAR);
      end else if (pick < 96) begin
        offer_item(ACT_ERASE, $urandom, 1'b0, ANS_CLEAR);
      end else begin
        offer_item(ACT_UNUSED, $urandom, 1'b0, ANS_CLEAR);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : answer_check
    index_answer_t want;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result, expected none, got status %0d slot %0d",
                 $time, m_tuser_o, m_tdata_o[9:0]);
        mismatches++;
      end else begin
        want = pending_answers.pop_front();
        check_field("status", 32'(want.status), 32'(m_tuser_o));
        check_field("slot_index", 32'(want.slot), 32'(m_tdata_o[9:0]));
        check_field("key_addr", want.key_addr, m_tdata_o[41:10]);
        check_field("record_addr", want.rec_addr, m_tdata_o[73:42]);
        check_field("replaced", 32'(want.replaced), 32'(m_tdata_o[74]));
        check_field("replaced_slot", 32'(want.repl_slot), 32'(m_tdata_o[84:75]));
        check_field("padding", 32'd0, 32'(m_tdata_o[87:85]));
        if (want.status == STAT_FULL) full_seen++;
        if (want.status == STAT_OK && want.key_addr != 0) hits_seen++;
        if (want.replaced) replaced_seen++;
      end
      answers_seen++;
    end
    if (hold_left != 0) begin
      m_tready_i <= 1'b0;
      hold_left--;
    end else if (answers_seen == HOLD_AT && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      m_tready_i <= 1'b0;
    end else begin
      m_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // The slowest legal request scans every slot and then waits on the divider; the limit
  // leaves a wide margin over that for every item and stall.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, pending_answers.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned row;
    foreach (slot_mem[j]) slot_mem[j] = '1;
    reg_isec   = RST_INDEX_SECTORS;
    reg_pps    = RST_PAGES_PER_SECTOR;
    reg_pb     = RST_PAGE_BYTES;
    reg_sb     = RST_SECTOR_BYTES;
    reg_spp    = RST_SLOTS_PER_PAGE;
    reg_rpp    = RST_RECORDS_PER_PAGE;
    reg_stride = RST_RECORD_STRIDE;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (row = 0; row < DIR_ROWS; row++) begin
      if (row == DIR_SPLIT) apply_setting(1, 2, 256, 4096, 4, 6, 40);
      offer_item(DIRECTED[row].act, DIRECTED[row].key, DIRECTED[row].typed,
                 DIRECTED[row].want);
    end

    apply_setting(2, 2, 256, 4096, 8, 6, 40);
    run_phase(110);
    apply_setting(4096, 4096, 65536, 16777216, 65536, 65536, 65536);
    run_phase(60);
    apply_setting(3, 1, 1, 1, 5, 0, 4);
    run_phase(80);
    apply_setting(1, 0, 512, 8192, 3, 4, 8);
    run_phase(20);
    apply_setting(5, 3, 128, 2048, 0, 2, 12);
    run_phase(20);
    apply_setting(1, 1, 64, 1024, 1, 1, 16);
    run_phase(40);
    repeat (3) begin
      apply_setting($urandom_range(4, 1), $urandom_range(4, 1), $urandom_range(65536, 1),
                    $urandom_range(16777216, 1), $urandom_range(8, 1),
                    $urandom_range(16, 0), $urandom_range(65536, 4));
      run_phase(70);
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Checked %0d results from %0d requests over %0d register settings.",
             answers_seen, items_sent, settings_used);
    $display("Answers with an address %0d, replaced copies %0d, full index %0d.",
             hits_seen, replaced_seen, full_seen);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
hdl/fkie_pkg.sv
hdl/fkie_div.sv
hdl/flash_key_index_engine_core.sv
verif/flash_key_index_engine_core_tb.sv
